### rtl/core/directory_entry_table_defines.svh
// ----------------------------------------------------------------------------
// Directory entry table assertion macros
// Shared property forms for the checker of the directory entry table.
// ----------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_TABLE_DEFINES_SVH
`define DIRECTORY_ENTRY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DET_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that is also checked during reset.
`define DET_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/core/det_pkg.sv
// ----------------------------------------------------------------------------
// Directory entry table package
// Sizes, entry layout, command codes and the name normalization function.
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int unsigned ENTRY_COUNT = 64;
  localparam int unsigned NAME_BYTES  = 13;
  localparam int unsigned NAME_SLOT   = 13;
  localparam int unsigned ADDR_W      = $clog2(ENTRY_COUNT);
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned NAME_W      = 8 * NAME_SLOT;
  localparam int unsigned ENTRY_W     = 16 + NAME_W;
  localparam logic [7:0]  FOLDER_MARK = 8'hFF;

  typedef enum logic [1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_FIND_EMPTY = 2'd1,
    CMD_WRITE      = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Zeroes every byte from the first zero byte on, and every byte at or
  // beyond the given length limit.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw,
                                                   input int unsigned limit);
    logic              ended;
    logic [7:0]        b;
    logic [NAME_W-1:0] res;
    ended = 1'b0;
    res   = '0;
    for (int unsigned k = 0; k < NAME_SLOT; k++) begin
      b = raw[8*k +: 8];
      if (b == 8'd0 || k >= limit) begin
        ended = 1'b1;
      end
      res[8*k +: 8] = ended ? 8'd0 : b;
    end
    return res;
  endfunction

endpackage

### rtl/core/directory_entry_table.sv
// ----------------------------------------------------------------------------
// Directory entry table
// Stores 64 directory entries in one memory and serves lookup, empty-entry
// search and write commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and exactly one
// result follows as a one-cycle pulse on out_strobe with out_found and
// out_index. The receiver cannot stall, so every result must be captured in
// the cycle its strobe is high. A write or an unused command answers in the
// cycle right after the transfer and leaves busy low, so another command can
// follow at once. A lookup or an empty-entry search walks the entry memory
// in index order at one read per cycle through its single read port; it
// raises busy, stops at the first hit, and registers its result once the
// read data of the hit entry, or of the last entry when none hits, has been
// checked. A missed lookup reports index 63, a failed empty search reports
// index 0. All entries read as zero after reset: each entry has a valid
// flag that reset clears, so no clearing pass is needed and the block takes
// commands in the first cycle after reset.
module directory_entry_table
  import det_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_command,
  input  logic [7:0]   in_parent,
  input  logic         in_want_folder,
  input  logic [7:0]   in_sector,
  input  logic [63:0]  in_name_low,
  input  logic [39:0]  in_name_high,
  input  logic [5:0]   in_entry_index,
  output logic         out_strobe,
  output logic         out_found,
  output logic [5:0]   out_index
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);

  // Entry memory and the per-entry valid flags that stand for the reset value.
  logic [ENTRY_W-1:0]     mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid_r, valid_nxt;

  // Control state.
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;       // next address to read
  logic              issue_r, issue_nxt;     // reads still to be issued
  logic              chk_v_r, chk_v_nxt;     // read data is waiting to be checked
  logic [ADDR_W-1:0] chk_idx_r, chk_idx_nxt; // address of that read data
  logic              out_strobe_r, out_strobe_nxt;
  logic              out_found_r, out_found_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;

  // Operands of the running scan.
  logic              op_lookup_r;
  logic [7:0]        op_parent_r;
  logic              op_folder_r;
  logic [NAME_W-1:0] op_name_r;
  logic              op_load;

  // Memory port signals.
  logic               rd_en;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_word;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_live_r;

  logic [NAME_W-1:0]  in_name;
  logic               write_ok;
  logic [ENTRY_W-1:0] ent;
  logic [7:0]         ent_parent;
  logic [7:0]         ent_sector;
  logic [NAME_W-1:0]  ent_name;
  logic               hit;

  assign in_name  = {in_name_high, in_name_low};
  assign write_ok = ({1'b0, in_entry_index} < 7'(ENTRY_COUNT));
  assign wr_addr  = in_entry_index[ADDR_W-1:0];
  assign wr_word  = {norm_name(in_name, NAME_BYTES), in_sector, in_parent};

  // An entry never written since reset reads as all zero.
  assign ent        = rd_live_r ? rd_data_r : '0;
  assign ent_parent = ent[7:0];
  assign ent_sector = ent[15:8];
  assign ent_name   = ent[ENTRY_W-1:16];

  // Lookup matches parent, normalized name and kind. The empty test needs a
  // zero parent, a zero sector and a zero first name byte.
  always_comb begin
    if (op_lookup_r) begin
      hit = (ent_parent == op_parent_r) && (ent_name == op_name_r) &&
            ((ent_sector == FOLDER_MARK) == op_folder_r);
    end else begin
      hit = (ent_parent == 8'd0) && (ent_sector == 8'd0) && (ent_name[7:0] == 8'd0);
    end
  end

  // Next state and outputs.
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    issue_nxt      = issue_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = out_found_r;
    out_index_nxt  = out_index_r;
    valid_nxt      = valid_r;
    op_load        = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_LOOKUP, CMD_FIND_EMPTY: begin
              state_nxt = ST_SCAN;
              addr_nxt  = '0;
              issue_nxt = 1'b1;
              op_load   = 1'b1;
            end
            CMD_WRITE: begin
              wr_en          = write_ok;
              out_strobe_nxt = 1'b1;
              out_found_nxt  = write_ok;
              out_index_nxt  = in_entry_index;
              if (write_ok) begin
                valid_nxt[wr_addr] = 1'b1;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_found_nxt  = 1'b0;
              out_index_nxt  = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous one is checked.
        if (issue_r) begin
          rd_en       = 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = addr_r;
          if (addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (chk_v_r) begin
          priority if (hit) begin
            state_nxt      = ST_IDLE;
            issue_nxt      = 1'b0;
            chk_v_nxt      = 1'b0;
            out_strobe_nxt = 1'b1;
            out_found_nxt  = 1'b1;
            out_index_nxt  = INDEX_W'(chk_idx_r);
          end else if (chk_idx_r == LAST_ADDR) begin
            state_nxt      = ST_IDLE;
            issue_nxt      = 1'b0;
            chk_v_nxt      = 1'b0;
            out_strobe_nxt = 1'b1;
            out_found_nxt  = 1'b0;
            out_index_nxt  = op_lookup_r ? INDEX_W'(LAST_ADDR) : '0;
          end else begin
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_r      <= 1'b0;
      chk_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      chk_v_r      <= chk_v_nxt;
      out_strobe_r <= out_strobe_nxt;
      valid_r      <= valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    if (op_load) begin
      op_lookup_r <= (in_command == CMD_LOOKUP);
      op_parent_r <= in_parent;
      op_folder_r <= in_want_folder;
      op_name_r   <= norm_name(in_name, NAME_SLOT);
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
      rd_live_r <= valid_r[addr_r];
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_found  = out_found_r;
  assign out_index  = out_index_r;

endmodule

### rtl/core/det_checker.sv
// ----------------------------------------------------------------------------
// Directory entry table checker
// Port-level checks of command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "directory_entry_table_defines.svh"

module det_checker
  import det_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_command,
  input logic [5:0]  in_entry_index,
  input logic        out_strobe,
  input logic        out_found,
  input logic [5:0]  out_index
);

  logic acc_write;
  logic acc_scan;
  logic reply_ok;

  assign acc_write = start && !busy && (in_command == CMD_WRITE);
  assign acc_scan  = start && !busy &&
                     ((in_command == CMD_LOOKUP) || (in_command == CMD_FIND_EMPTY));
  assign reply_ok  = out_strobe && out_found;

  // A write answers in the next cycle with found set and its own index.
  `DET_ASSERT_NEXT(a_write_reply, acc_write, reply_ok && (out_index == $past(in_entry_index)))
  // A scan command holds the block busy for at least the next cycle.
  `DET_ASSERT_NEXT(a_scan_busy, acc_scan, busy)
  // A result is never shown while a scan is still running.
  `DET_ASSERT_SAME(a_strobe_idle, out_strobe, !busy)
  // The end of a scan always delivers its result.
  `DET_ASSERT_SAME(a_scan_end_reply, $fell(busy), out_strobe)
  // Reset leaves no result pending.
  `DET_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_strobe && !busy)

endmodule

bind directory_entry_table det_checker u_det_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .in_entry_index (in_entry_index),
  .out_strobe     (out_strobe),
  .out_found      (out_found),
  .out_index      (out_index)
);
